/* rtl/core/abpd_pkg.sv */
// abpd_pkg: shared types, register indexes and reset values for the beat detector
// used by abpd_core and audio_beat_party_detector_unit; no dependencies

package abpd_pkg;

  // background average span, windows are averaged over this plus one
  localparam int AVG_WINDOWS_DEF = 200;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SAMPLES = 3'd0,
    REG_PEAK_THRESHOLD = 3'd1,
    REG_PEAKS_TO_ENTER = 3'd2,
    REG_PEAK_WINDOW    = 3'd3,
    REG_PARTY_DURATION = 3'd4
  } cfg_index_t;

  localparam logic [7:0]  WINDOW_SAMPLES_RST = 8'd100;
  localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd993;
  localparam logic [7:0]  PEAKS_TO_ENTER_RST = 8'd20;
  localparam logic [7:0]  PEAK_WINDOW_RST    = 8'd200;
  localparam logic [15:0] PARTY_DURATION_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]  window_samples;
    logic [15:0] peak_threshold;
    logic [7:0]  peaks_to_enter;
    logic [7:0]  peak_window;
    logic [15:0] party_duration;
  } cfg_t;

  typedef struct packed {
    logic       idle;
    logic       preboot;
    logic       listen_enable;
    logic [7:0] sample;
  } item_t;

  typedef struct packed {
    logic        window_end;
    logic [7:0]  amplitude;
    logic [15:0] background_level;
    logic        peaking;
    logic        party_active;
    logic        party_entered;
    logic        party_left;
    logic        party_beat;
    logic        test_beat;
  } result_t;

endpackage

/* rtl/core/abpd_core.sv */
// abpd_core: detector state and the per-sample update, one sample per step
// depends on abpd_pkg

module abpd_core #(
  parameter int AVG_WINDOWS = abpd_pkg::AVG_WINDOWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  abpd_pkg::item_t   item,
  input  abpd_pkg::cfg_t    cfg,
  output abpd_pkg::result_t res
);
  import abpd_pkg::*;

  // constant divisor, exact reciprocal for 24-bit dividends
  localparam int          DIV     = AVG_WINDOWS + 1;
  localparam int          AVG_W   = $clog2(AVG_WINDOWS + 2);
  localparam longint unsigned RECIP_L = ((64'd1 << 32) + DIV - 1) / DIV;
  localparam logic [32:0] RECIP   = RECIP_L[32:0];
  localparam logic [AVG_W-1:0] AVG_LIMIT = AVG_W'(AVG_WINDOWS);
  localparam logic [AVG_W-1:0] AVG_RESTART = AVG_W'(2);
  localparam logic [AVG_W-1:0] AVG_ONE = AVG_W'(1);

  logic [7:0]       window_min, window_max, window_count, last_amplitude;
  logic [23:0]      level_sum;
  logic [AVG_W-1:0] avg_window_count;
  logic [15:0]      background_avg;
  logic [7:0]       spike_window_count, spike_count;
  logic             peak_now, party_on;
  logic [15:0]      party_remaining;

  logic [7:0]       window_min_next, window_max_next, window_count_next, last_amplitude_next;
  logic [23:0]      level_sum_next;
  logic [AVG_W-1:0] avg_window_count_next;
  logic [15:0]      background_avg_next;
  logic [7:0]       spike_window_count_next, spike_count_next;
  logic             peak_now_next, party_on_next;
  logic [15:0]      party_remaining_next;

  logic [7:0]  count_inc, run_max, run_min, amp;
  logic [15:0] level;
  logic [56:0] product;
  logic [15:0] quotient;
  logic [16:0] margin;
  logic [7:0]  spikes_base, spikes_inc;
  logic        wend, spike, on_after_timeout;
  logic        entered, left, beat, tbeat;

  // quotient of the stored sum, used only when the average closes
  assign product  = 57'(level_sum) * 57'(RECIP);
  assign quotient = product[47:32];

  always_comb begin
    count_inc = window_count + 8'd1;
    run_max   = window_max;
    run_min   = window_min;
    if (item.sample > window_max) begin
      run_max = item.sample;
    end else if (item.sample < window_min) begin
      run_min = item.sample;
    end
    wend  = (count_inc == cfg.window_samples);
    amp   = run_max - run_min;
    level = {amp, 8'h00};

    window_min_next          = run_min;
    window_max_next          = run_max;
    window_count_next        = count_inc;
    last_amplitude_next      = last_amplitude;
    level_sum_next           = level_sum;
    avg_window_count_next    = avg_window_count;
    background_avg_next      = background_avg;
    spike_window_count_next  = spike_window_count;
    spike_count_next         = spike_count;
    peak_now_next            = peak_now;
    party_on_next            = party_on;
    party_remaining_next     = party_remaining;
    on_after_timeout         = party_on;
    spikes_base              = spike_count;
    spikes_inc               = spike_count;
    margin                   = '0;
    spike                    = 1'b0;
    entered                  = 1'b0;
    left                     = 1'b0;
    beat                     = 1'b0;
    tbeat                    = 1'b0;

    if (wend) begin
      last_amplitude_next = amp;
      window_min_next     = 8'hff;
      window_max_next     = 8'h00;
      window_count_next   = 8'h00;

      // party countdown, timeout when it reaches zero
      if (party_on && (party_remaining == 16'd0)) begin
        on_after_timeout = 1'b0;
        left             = 1'b1;
      end else if (party_on) begin
        party_remaining_next = party_remaining - 16'd1;
      end

      // background average, last average seeds the next sum
      if (avg_window_count > AVG_LIMIT) begin
        background_avg_next   = quotient;
        level_sum_next        = 24'(quotient) + 24'(level);
        avg_window_count_next = AVG_RESTART;
      end else begin
        avg_window_count_next = avg_window_count + AVG_ONE;
        level_sum_next        = level_sum + 24'(level);
      end

      if (spike_window_count > cfg.peak_window) begin
        spikes_base             = 8'd0;
        spike_window_count_next = 8'd0;
      end else begin
        spike_window_count_next = spike_window_count + 8'd1;
      end

      margin        = 17'(background_avg_next) + 17'(cfg.peak_threshold);
      peak_now_next = (17'(level) > margin);
      spike         = peak_now_next && !peak_now;
      spikes_inc    = spikes_base + 8'd1;
      spike_count_next = spikes_base;
      party_on_next    = on_after_timeout;

      if (!on_after_timeout && item.listen_enable && !item.preboot && spike) begin
        spike_count_next = spikes_inc;
        if (spikes_inc > cfg.peaks_to_enter) begin
          party_on_next        = 1'b1;
          party_remaining_next = cfg.party_duration;
          entered              = 1'b1;
        end
      end else if (spike && on_after_timeout && item.idle) begin
        beat = 1'b1;
      end else if (spike && item.preboot) begin
        tbeat = 1'b1;
      end
    end

    res.window_end       = wend;
    res.amplitude        = last_amplitude_next;
    res.background_level = background_avg_next;
    res.peaking          = peak_now_next;
    res.party_active     = party_on_next;
    res.party_entered    = entered;
    res.party_left       = left;
    res.party_beat       = beat;
    res.test_beat        = tbeat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_min         <= 8'hff;
      window_max         <= 8'h00;
      window_count       <= 8'h00;
      last_amplitude     <= 8'h00;
      level_sum          <= '0;
      avg_window_count   <= '0;
      background_avg     <= '0;
      spike_window_count <= 8'h00;
      spike_count        <= 8'h00;
      peak_now           <= 1'b0;
      party_on           <= 1'b0;
      party_remaining    <= '0;
    end else if (step) begin
      window_min         <= window_min_next;
      window_max         <= window_max_next;
      window_count       <= window_count_next;
      last_amplitude     <= last_amplitude_next;
      level_sum          <= level_sum_next;
      avg_window_count   <= avg_window_count_next;
      background_avg     <= background_avg_next;
      spike_window_count <= spike_window_count_next;
      spike_count        <= spike_count_next;
      peak_now           <= peak_now_next;
      party_on           <= party_on_next;
      party_remaining    <= party_remaining_next;
    end
  end

endmodule

/* rtl/core/audio_beat_party_detector_unit.sv */
// audio_beat_party_detector_unit: top level of the peak-to-peak beat detector
// depends on abpd_pkg and abpd_core
//
//  channel   | direction | request carries
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one microphone sample with its mode flags
//  m_axis    | out       | one result per sample, tlast marks a window end
//  cfg       | in        | register index and write data
//
// one sample per clock sustained while m_axis does not stall; a sample is
// registered in the input register, then its result in the result register.
// the slowest path is the constant-reciprocal multiply of the stored level
// sum followed by the threshold compare. rst is synchronous: clears all
// detector state, loads register defaults and empties both stages. a stalled
// m_axis holds the result stage and drops s_axis_tready once in_valid is set.

module audio_beat_party_detector_unit #(
  parameter int AVG_WINDOWS = abpd_pkg::AVG_WINDOWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_axis_tdata: sample[7:0], listen_enable[8], preboot[9], idle[10], zeros above
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [abpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // m_axis_tdata: amplitude[7:0], background_level[23:8], peaking[24],
  // party_active[25], party_entered[26], party_left[27], party_beat[28],
  // test_beat[29], zeros above; tlast is window_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [abpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [abpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import abpd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res_comb;
  result_t res;
  logic    out_valid;
  logic    advance;
  logic    step;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_samples <= WINDOW_SAMPLES_RST;
      cfg.peak_threshold <= PEAK_THRESHOLD_RST;
      cfg.peaks_to_enter <= PEAKS_TO_ENTER_RST;
      cfg.peak_window    <= PEAK_WINDOW_RST;
      cfg.party_duration <= PARTY_DURATION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        REG_WINDOW_SAMPLES: cfg.window_samples <= cfg_data[7:0];
        REG_PEAK_THRESHOLD: cfg.peak_threshold <= cfg_data;
        REG_PEAKS_TO_ENTER: cfg.peaks_to_enter <= cfg_data[7:0];
        REG_PEAK_WINDOW:    cfg.peak_window    <= cfg_data[7:0];
        REG_PARTY_DURATION: cfg.party_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  // result stage can take a new result when empty or being drained
  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= item_t'(s_axis_tdata[10:0]);
    end
  end

  abpd_core #(
    .AVG_WINDOWS(AVG_WINDOWS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_comb;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.window_end;
  assign m_axis_tdata  = {2'b00, res.test_beat, res.party_beat, res.party_left,
                          res.party_entered, res.party_active, res.peaking,
                          res.background_level, res.amplitude};

endmodule
